/* hw/rtl/nfass_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfass_pkg: shared types and constants of the nfa state set stepper
// Field widths, command and register codes, and the control/status bundles
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package nfass_pkg;

  // default sizing of the automaton
  localparam int DEF_NUM_STATES    = 16;
  localparam int DEF_ALPHABET_SIZE = 16;

  // fixed port widths
  localparam int CMD_W       = 2;
  localparam int SYM_W       = 4;
  localparam int STATE_IDX_W = 4;
  localparam int MASK_W      = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  // widest supported state set, used for explicit zero extension
  localparam int SET_EXT_W = 64;

  // request commands
  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_STATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MASK   = 1'd1;

  // commands from controller to datapath
  typedef struct packed {
    logic clear_wr;
    logic load;
    logic row_wr;
    logic restart;
    logic scan_init;
    logic close_init;
    logic scan;
    logic commit;
    logic out_load;
  } dp_ctl_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic scan_done;
  } dp_sts_t;

endpackage
`default_nettype wire

/* hw/rtl/nfass_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfass_dp: datapath of the nfa state set stepper
// Transition memory, active set, scan counter with pending mask, config
// registers and the result register.
// ----------------------------------------------------------------------------
module nfass_dp #(
  parameter int NUM_STATES    = nfass_pkg::DEF_NUM_STATES,
  parameter int ALPHABET_SIZE = nfass_pkg::DEF_ALPHABET_SIZE
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  nfass_pkg::dp_ctl_t                   ctl,
  output nfass_pkg::dp_sts_t                   sts,
  input  logic [nfass_pkg::SYM_W-1:0]          in_symbol,
  input  logic [nfass_pkg::STATE_IDX_W-1:0]    in_from_state,
  input  logic [nfass_pkg::MASK_W-1:0]         in_row_targets,
  input  logic                                 cfg_wr,
  input  logic [nfass_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nfass_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [nfass_pkg::MASK_W-1:0]         out_active_set,
  output logic                                 out_accepted
);
  import nfass_pkg::*;

  localparam int SET_W  = NUM_STATES;
  localparam int QW     = $clog2(NUM_STATES);
  localparam int SW     = $clog2(ALPHABET_SIZE);
  localparam int AW     = QW + SW;
  localparam int DEPTH  = 1 << AW;
  localparam int LAST_Q = NUM_STATES - 1;

  // transition memory, one row per (state, symbol)
  logic [SET_W-1:0] mem [DEPTH];

  logic [SET_W-1:0]       active_r;
  logic [SET_W-1:0]       set_r, set_nxt;
  logic [SET_W-1:0]       todo_r, todo_nxt;
  logic [SET_W-1:0]       rd_data_r;
  logic [SET_W-1:0]       new_bits;
  logic [SET_W-1:0]       q_bit;
  logic [SET_W-1:0]       start_set;
  logic [SET_W-1:0]       wr_data;
  logic [QW-1:0]          q_r, q_nxt;
  logic                   inflight_r, inflight_nxt;
  logic                   closing_r;
  logic [AW-1:0]          clr_r;
  logic [AW-1:0]          wr_addr, rd_addr;
  logic                   wr_en, rd_en, issue;
  logic [SW-1:0]          sym_sel;
  logic [SYM_W-1:0]       sym_r;
  logic [STATE_IDX_W-1:0] from_r;
  logic [MASK_W-1:0]      targets_r;
  logic [STATE_IDX_W-1:0] init_r;
  logic [MASK_W-1:0]      accept_r;
  logic [31:0]            sym_ext, from_ext, init_ext;
  logic [SET_EXT_W-1:0]   targets_ext, act_ext;
  logic                   sym_ok, from_ok, init_ok;
  logic [MASK_W-1:0]      out_set_r;
  logic                   out_acc_r;

  // range checks on the latched request and the start state
  assign sym_ext     = 32'(sym_r);
  assign from_ext    = 32'(from_r);
  assign init_ext    = 32'(init_r);
  assign targets_ext = SET_EXT_W'(targets_r);
  assign act_ext     = SET_EXT_W'(active_r);
  assign sym_ok      = sym_ext < 32'(ALPHABET_SIZE);
  assign from_ok     = from_ext < 32'(NUM_STATES);
  assign init_ok     = init_ext < 32'(NUM_STATES);
  assign start_set   = init_ok ? (SET_W'(1) << init_r) : '0;

  // memory write port: clearing sweep or row write
  assign wr_en   = ctl.clear_wr | (ctl.row_wr & from_ok & sym_ok);
  assign wr_addr = ctl.clear_wr ? clr_r : {from_ext[QW-1:0], sym_ext[SW-1:0]};
  assign wr_data = ctl.clear_wr ? '0 : targets_ext[SET_W-1:0];

  // memory read port: row of the scanned state, epsilon column while closing
  assign sym_sel  = closing_r ? '0 : sym_ext[SW-1:0];
  assign rd_addr  = {q_r, sym_sel};
  assign issue    = ctl.scan & todo_r[q_r];
  assign rd_en    = issue;
  assign q_bit    = SET_W'(1) << q_r;
  assign new_bits = rd_data_r & ~set_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // scan engine: visit pending states, fold in returned rows
  always_comb begin
    set_nxt      = set_r;
    todo_nxt     = todo_r;
    q_nxt        = q_r;
    inflight_nxt = inflight_r;
    if (ctl.scan_init) begin
      set_nxt      = '0;
      todo_nxt     = sym_ok ? active_r : '0;
      q_nxt        = '0;
      inflight_nxt = 1'b0;
    end else if (ctl.close_init) begin
      todo_nxt     = set_r;
      q_nxt        = '0;
      inflight_nxt = 1'b0;
    end else if (ctl.scan) begin
      if (issue) begin
        todo_nxt = todo_r & ~q_bit;
      end
      if (inflight_r) begin
        set_nxt = set_r | rd_data_r;
        // newly reached states still need their epsilon rows
        if (closing_r) begin
          todo_nxt = todo_nxt | new_bits;
        end
      end
      q_nxt        = (q_r == QW'(LAST_Q)) ? '0 : q_r + 1'b1;
      inflight_nxt = issue;
    end
  end

  assign sts.scan_done = (todo_r == '0) && !inflight_r;
  assign sts.clr_last  = &clr_r;

  // control state of the scan engine and clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      todo_r     <= '0;
      q_r        <= '0;
      inflight_r <= 1'b0;
      closing_r  <= 1'b0;
      clr_r      <= '0;
    end else begin
      todo_r     <= todo_nxt;
      q_r        <= q_nxt;
      inflight_r <= inflight_nxt;
      if (ctl.scan_init) begin
        closing_r <= 1'b0;
      end else if (ctl.close_init) begin
        closing_r <= 1'b1;
      end
      if (ctl.clear_wr) begin
        clr_r <= clr_r + 1'b1;
      end
    end
  end

  // gathered set
  always_ff @(posedge clk) begin
    set_r <= set_nxt;
  end

  // latched request fields
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sym_r     <= in_symbol;
      from_r    <= in_from_state;
      targets_r <= in_row_targets;
    end
  end

  // active set and config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= SET_W'(1);
      init_r   <= '0;
      accept_r <= '0;
    end else begin
      if (ctl.restart) begin
        active_r <= start_set;
      end else if (ctl.commit) begin
        active_r <= set_r;
      end
      if (cfg_wr) begin
        case (cfg_index)
          CFG_INITIAL_STATE: init_r   <= cfg_data[STATE_IDX_W-1:0];
          CFG_ACCEPT_MASK:   accept_r <= cfg_data[MASK_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_set_r <= act_ext[MASK_W-1:0];
      out_acc_r <= |(act_ext[MASK_W-1:0] & accept_r);
    end
  end

  assign out_active_set = out_set_r;
  assign out_accepted   = out_acc_r;

endmodule
`default_nettype wire

/* hw/rtl/nfass_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfass_ctrl: controller of the nfa state set stepper
// Sequences the clearing sweep, request decode, symbol and epsilon scans and
// the result handshake.
// ----------------------------------------------------------------------------
module nfass_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [nfass_pkg::CMD_W-1:0] in_command,
  output logic                        out_valid,
  input  logic                        out_ready,
  output nfass_pkg::dp_ctl_t          ctl,
  input  nfass_pkg::dp_sts_t          sts
);
  import nfass_pkg::*;

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_WRITE   = 3'd2;
  localparam logic [2:0] ST_RESTART = 3'd3;
  localparam logic [2:0] ST_STEP    = 3'd4;
  localparam logic [2:0] ST_GATHER  = 3'd5;
  localparam logic [2:0] ST_CLOSE   = 3'd6;
  localparam logic [2:0] ST_FINISH  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  // next state and datapath commands
  always_comb begin
    ctl           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    in_ready      = (state_r == ST_IDLE);
    case (state_r)
      ST_CLEAR: begin
        ctl.clear_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          ctl.load = 1'b1;
          case (in_command)
            CMD_WRITE:   state_nxt = ST_WRITE;
            CMD_RESTART: state_nxt = ST_RESTART;
            CMD_STEP:    state_nxt = ST_STEP;
            default:     state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_WRITE: begin
        ctl.row_wr = 1'b1;
        state_nxt  = ST_FINISH;
      end
      ST_RESTART: begin
        ctl.restart = 1'b1;
        state_nxt   = ST_FINISH;
      end
      ST_STEP: begin
        ctl.scan_init = 1'b1;
        state_nxt     = ST_GATHER;
      end
      ST_GATHER: begin
        if (sts.scan_done) begin
          ctl.close_init = 1'b1;
          state_nxt      = ST_CLOSE;
        end else begin
          ctl.scan = 1'b1;
        end
      end
      ST_CLOSE: begin
        if (sts.scan_done) begin
          ctl.commit = 1'b1;
          state_nxt  = ST_FINISH;
        end else begin
          ctl.scan = 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          ctl.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

/* hw/rtl/nfa_state_set_stepper.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfa_state_set_stepper: bit-parallel NFA simulation with epsilon closure
// Holds the active state set as a mask and steps it one symbol per request.
// ----------------------------------------------------------------------------
// After reset the block sweeps all 2**(clog2(NUM_STATES)+clog2(ALPHABET_SIZE))
// rows of its transition memory (256 with the defaults) to zero, one row per
// cycle, and takes no request meanwhile; config writes are taken at any
// time. Requests are handled one at a time and each gives one result. A row
// write or a restart passes through its own state to the finish state, an
// unused command goes straight there, and the finish state loads the result
// once the result register is free. A step runs a state counter over all
// states, which reads the row of each pending state from the transition memory,
// at most one row per cycle: first the symbol rows of the active states, then
// the epsilon rows of every gathered state and of every newly reached one, lap
// after lap until none is pending. The result register lets the next request
// in while a result waits to be taken.
module nfa_state_set_stepper #(
  parameter int NUM_STATES    = nfass_pkg::DEF_NUM_STATES,
  parameter int ALPHABET_SIZE = nfass_pkg::DEF_ALPHABET_SIZE
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [nfass_pkg::CMD_W-1:0]       in_command,
  input  logic [nfass_pkg::SYM_W-1:0]       in_symbol,
  input  logic [nfass_pkg::STATE_IDX_W-1:0] in_from_state,
  input  logic [nfass_pkg::MASK_W-1:0]      in_row_targets,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [nfass_pkg::MASK_W-1:0]      out_active_set,
  output logic                              out_accepted,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nfass_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nfass_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import nfass_pkg::*;

  dp_ctl_t ctl;
  dp_sts_t sts;

  // config writes are always accepted
  assign cfg_ready = 1'b1;

  nfass_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ctl        (ctl),
    .sts        (sts)
  );

  nfass_dp #(
    .NUM_STATES    (NUM_STATES),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .sts            (sts),
    .in_symbol      (in_symbol),
    .in_from_state  (in_from_state),
    .in_row_targets (in_row_targets),
    .cfg_wr         (cfg_valid & cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_active_set (out_active_set),
    .out_accepted   (out_accepted)
  );

endmodule
`default_nettype wire

/* hw/rtl/nfass_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfass_checker: port-level checks of the nfa state set stepper
// Watches the request and result channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module nfass_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [nfass_pkg::MASK_W-1:0]      out_active_set,
  input logic                              out_accepted
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_active_set) && $stable(out_accepted))
    else $error("result changed while stalled");

  // no result is pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one request at a time: no acceptance in the cycle after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted back to back");

  // an empty set can never be accepting
  a_empty_rejects: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_active_set == '0) |-> !out_accepted)
    else $error("accepted flag with empty set");

endmodule

bind nfa_state_set_stepper nfass_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_active_set (out_active_set),
  .out_accepted   (out_accepted)
);
`default_nettype wire
